FILE: rtl/core/crc16fc_pkg.sv
// ----------------------------------------------------------------------------
// crc16fc_pkg
// Shared constants and codes of the CRC-16 frame checker.
// ----------------------------------------------------------------------------
package crc16fc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  START_MARK = 8'hAA;
  localparam logic [7:0]  MAX_LENGTH_RESET = 8'd64;

  // byte position covers header, up to 255 payload bytes and two CRC bytes
  localparam int unsigned POS_W = 9;
  localparam int unsigned HDR_LEN = 3;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LENGTH = 2'd1,
    ST_CRC    = 2'd2,
    ST_START  = 2'd3
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

endpackage

FILE: rtl/core/crc16fc_in_if.sv
// ----------------------------------------------------------------------------
// crc16fc_in_if
// Received byte channel: one byte per transfer with a frame start flag.
// ----------------------------------------------------------------------------
interface crc16fc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

FILE: rtl/core/crc16fc_out_if.sv
// ----------------------------------------------------------------------------
// crc16fc_out_if
// Result channel: payload bytes and end of frame status.
// ----------------------------------------------------------------------------
interface crc16fc_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] payload_byte;
  logic [7:0] message_type;
  logic [7:0] msg_length;
  logic [1:0] status;

  modport source (output valid, output result_kind, output payload_byte,
                  output message_type, output msg_length, output status,
                  input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input message_type, input msg_length, input status,
                  output ready);
endinterface

FILE: rtl/core/crc16fc_crc_byte.sv
// ----------------------------------------------------------------------------
// crc16fc_crc_byte
// One byte update of a reflected CRC-16 (MODBUS polynomial), bit by bit.
// ----------------------------------------------------------------------------
module crc16fc_crc_byte (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data_in};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ crc16fc_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

FILE: rtl/core/crc16_frame_checker.sv
// ----------------------------------------------------------------------------
// crc16_frame_checker
// Deframer with running CRC-16/MODBUS check and length limit.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus carries one received byte per transfer; frame_start marks the
//   first byte of a frame (start, type, length, payload, CRC high, CRC low).
//   out_bus gives each payload byte as it arrives (result_kind 0) and one
//   status per frame (result_kind 1) after the CRC low byte, or right after
//   the length byte when it exceeds max_length. Discard the payload of a
//   frame whose status is not ok.
//   Throughput is one byte per cycle while no result waits on a stalled
//   out_bus: the CRC byte update and the frame position compare sit
//   between the input register and the result register, and out_bus.valid
//   comes from the result register.
//   When out_bus stalls, the input register still takes one byte; bytes
//   that give no result keep flowing, a byte with a result waits.
//   cfg_we writes max_length (64 after reset); write it only while idle.
//   Synchronous reset closes any open frame and empties both registers.
// ----------------------------------------------------------------------------
module crc16_frame_checker (
  input  logic                clk,
  input  logic                rst_n,
  crc16fc_in_if.sink          in_bus,
  crc16fc_out_if.source       out_bus,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);

  localparam int unsigned PW = crc16fc_pkg::POS_W;

  // input register
  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        in_start_r;

  // frame state
  logic [7:0]    max_len_r;
  logic          active_r, active_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    start_r, start_nxt;
  logic [7:0]    type_r, type_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [7:0]    crc_hi_r, crc_hi_nxt;

  // result register
  logic                  out_valid_r;
  crc16fc_pkg::kind_t    out_kind_r;
  logic [7:0]            out_byte_r;
  logic [7:0]            out_type_r;
  logic [7:0]            out_len_r;
  crc16fc_pkg::status_t  out_status_r;

  logic                  has_res;
  crc16fc_pkg::kind_t    res_kind;
  logic [7:0]            res_byte;
  crc16fc_pkg::status_t  res_status;

  logic          advance;
  logic          active_now;
  logic [PW-1:0] pos_now;
  logic [15:0]   crc_now;
  logic [15:0]   crc_fed;
  logic [PW-1:0] payload_end;

  assign active_now  = in_start_r | active_r;
  assign pos_now     = in_start_r ? '0 : pos_r;
  assign crc_now     = in_start_r ? crc16fc_pkg::CRC_INIT : crc_r;
  assign payload_end = PW'(crc16fc_pkg::HDR_LEN) + {{(PW-8){1'b0}}, len_r};

  crc16fc_crc_byte u_crc (
    .crc_in  (crc_now),
    .data_in (in_byte_r),
    .crc_out (crc_fed)
  );

  always_comb begin
    active_nxt = active_now;
    pos_nxt    = pos_now;
    start_nxt  = start_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    crc_nxt    = crc_now;
    crc_hi_nxt = crc_hi_r;
    has_res    = 1'b0;
    res_kind   = crc16fc_pkg::KIND_PAYLOAD;
    res_byte   = 8'h00;
    res_status = crc16fc_pkg::ST_OK;
    if (active_now) begin
      if (pos_now == PW'(0)) begin
        start_nxt = in_byte_r;
        crc_nxt   = crc_fed;
        pos_nxt   = PW'(1);
      end else if (pos_now == PW'(1)) begin
        type_nxt = in_byte_r;
        crc_nxt  = crc_fed;
        pos_nxt  = PW'(2);
      end else if (pos_now == PW'(2)) begin
        len_nxt = in_byte_r;
        crc_nxt = crc_fed;
        pos_nxt = PW'(3);
        if (in_byte_r > max_len_r) begin
          active_nxt = 1'b0;
          has_res    = 1'b1;
          res_kind   = crc16fc_pkg::KIND_STATUS;
          res_status = crc16fc_pkg::ST_LENGTH;
        end
      end else if (pos_now < payload_end) begin
        crc_nxt  = crc_fed;
        pos_nxt  = pos_now + PW'(1);
        has_res  = 1'b1;
        res_byte = in_byte_r;
      end else if (pos_now == payload_end) begin
        crc_hi_nxt = in_byte_r;
        pos_nxt    = pos_now + PW'(1);
      end else begin
        // closing byte: CRC first, then start mark
        active_nxt = 1'b0;
        pos_nxt    = pos_now + PW'(1);
        has_res    = 1'b1;
        res_kind   = crc16fc_pkg::KIND_STATUS;
        if ({crc_hi_r, in_byte_r} != crc_now) begin
          res_status = crc16fc_pkg::ST_CRC;
        end else if (start_r != crc16fc_pkg::START_MARK) begin
          res_status = crc16fc_pkg::ST_START;
        end else begin
          res_status = crc16fc_pkg::ST_OK;
        end
      end
    end
  end

  // hold a byte with a result while the result register is occupied and out_bus is not ready
  assign advance      = in_valid_r & (~has_res | ~out_valid_r | out_bus.ready);
  assign in_bus.ready = ~in_valid_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_bus.valid && in_bus.ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      in_byte_r  <= in_bus.rx_byte;
      in_start_r <= in_bus.frame_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= crc16fc_pkg::MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      max_len_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pos_r    <= '0;
      start_r  <= 8'h00;
      type_r   <= 8'h00;
      len_r    <= 8'h00;
      crc_r    <= crc16fc_pkg::CRC_INIT;
      crc_hi_r <= 8'h00;
    end else if (advance) begin
      active_r <= active_nxt;
      pos_r    <= pos_nxt;
      start_r  <= start_nxt;
      type_r   <= type_nxt;
      len_r    <= len_nxt;
      crc_r    <= crc_nxt;
      crc_hi_r <= crc_hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && has_res) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_res) begin
      out_kind_r   <= res_kind;
      out_byte_r   <= res_byte;
      out_type_r   <= type_nxt;
      out_len_r    <= len_nxt;
      out_status_r <= res_status;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.result_kind  = out_kind_r;
  assign out_bus.payload_byte = out_byte_r;
  assign out_bus.message_type = out_type_r;
  assign out_bus.msg_length   = out_len_r;
  assign out_bus.status       = out_status_r;

endmodule

FILE: rtl/core/crc16fc_checker.sv
// ----------------------------------------------------------------------------
// crc16fc_checker
// Port level checks of the CRC-16 frame checker, bound to the top level.
// ----------------------------------------------------------------------------
module crc16fc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_result_kind,
  input logic [7:0] out_payload_byte,
  input logic [7:0] out_message_type,
  input logic [7:0] out_msg_length,
  input logic [1:0] out_status
);

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind) &&
      $stable(out_payload_byte) && $stable(out_status) &&
      $stable(out_message_type) && $stable(out_msg_length))
    else $error("stalled result changed");

  a_payload_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == crc16fc_pkg::KIND_PAYLOAD |->
      out_status == crc16fc_pkg::ST_OK)
    else $error("payload transfer with nonzero status");

  a_status_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == crc16fc_pkg::KIND_STATUS |->
      out_payload_byte == 8'h00)
    else $error("status transfer with nonzero payload byte");

endmodule

bind crc16_frame_checker crc16fc_checker u_crc16fc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_bus.valid),
  .out_ready        (out_bus.ready),
  .out_result_kind  (out_bus.result_kind),
  .out_payload_byte (out_bus.payload_byte),
  .out_message_type (out_bus.message_type),
  .out_msg_length   (out_bus.msg_length),
  .out_status       (out_bus.status)
);
